// ----- design/sss_pkg.sv -----
// Package for the sample set statistics unit.
// Payload structs, register indexes, reset values. No dependencies.
package sss_pkg;

    localparam int unsigned MaxSamplesDefault = 32;
    localparam logic [14:0] RangeLowReset  = 15'd160;
    localparam logic [14:0] RangeHighReset = 15'd1440;
    localparam logic [14:0] PwrMax         = 15'h7FFF;

    localparam logic [0:0] RegRangeLow  = 1'b0;
    localparam logic [0:0] RegRangeHigh = 1'b1;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [14:0] min_power;
        logic [14:0] max_power;
        logic [14:0] mean_power;
        logic [14:0] median_power;
        logic        all_in_range;
        logic [5:0]  kept_count;
        logic        empty_res;
        logic        overflow;
    } out_item_t;

endpackage

// ----- design/sample_set_statistics_unit.sv -----
// Sample set statistics unit: top level with APB config, store and sequencer.
// Depends on sss_pkg.
//
// Usage: samples arrive on in_valid/in_ready as sss_pkg::in_item_t, one
// transaction per cycle while a set is collected. Negative samples are
// dropped. A transaction with last set closes the set: in_ready drops, the
// unit sorts the stored samples with one shared compare/swap unit (odd-even
// transposition, N passes of about N/2 pair steps, N = kept count), then
// divides sum by count with a restoring divider, one quotient bit per cycle.
// After the last sample the sort runs through the single compare/swap unit,
// each pair step a read state (ST_RD) then a compare state (ST_CMP), and
// then the divider; with N below 2 the sort is skipped.
// Loading throughput: one sample per cycle while no result is held.
// The result is held on out_valid/out_data until out_ready; a stalled
// receiver holds the unit, which takes no new sample until the result goes.
// Reset clears the set state and loads range_low=160, range_high=1440.
// Config: APB, range_low at 0x0, range_high at 0x4; pready is always high.
// Write configuration only while the unit is idle.
module sample_set_statistics_unit #(
    parameter int unsigned MAX_SAMPLES = sss_pkg::MaxSamplesDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sss_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sss_pkg::out_item_t out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sss_pkg::*;

    localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SW = 15 + CW;

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_RD   = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [14:0] range_low_reg, range_high_reg;
    logic [14:0] mem [MAX_SAMPLES];
    logic [CW-1:0] count_reg;
    logic [14:0] min_reg, max_reg;
    logic [SW-1:0] sum_reg;
    logic ok_reg, ovf_reg;
    logic [CW-1:0] pass_reg;
    logic [AW-1:0] idx_reg;
    logic [14:0] rd_a_reg, rd_b_reg;
    logic [14:0] med_lo_reg, med_hi_reg;
    logic [SW-1:0] rem_reg, quo_reg;
    logic [$clog2(SW+1)-1:0] bit_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {17'd0, range_high_reg} : {17'd0, range_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= RangeLowReset;
            range_high_reg <= RangeHighReset;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                RegRangeLow:  range_low_reg  <= pwdata[14:0];
                RegRangeHigh: range_high_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    logic in_fire, keep, full, pair_odd, do_swap, last_step;
    logic [AW-1:0] idx_max;
    logic [CW-1:0] half;
    logic [SW:0] trial;
    logic [SW-1:0] rem_sh;

    assign in_ready  = (state_reg == ST_LOAD) && !out_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign full      = (count_reg == CW'(MAX_SAMPLES));
    assign keep      = !in_data.sample[15];
    assign pair_odd  = pass_reg[0];
    assign idx_max   = AW'(count_reg - CW'(2));
    assign last_step = ({1'b0, idx_reg} + (AW+1)'(2)) > {1'b0, idx_max};
    assign do_swap   = (rd_a_reg > rd_b_reg) && (idx_reg <= idx_max);
    assign half      = count_reg >> 1;
    assign rem_sh    = {rem_reg[SW-2:0], sum_reg[bit_reg - 1'b1]};
    assign trial     = {1'b0, rem_sh} - {{(SW+1-CW){1'b0}}, count_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (in_fire && in_data.last)
                state_next = (count_reg > CW'(1) || (keep && !full && count_reg == CW'(1)))
                             ? ST_RD : ST_DIV;
            ST_RD:   state_next = ST_CMP;
            ST_CMP:  state_next = (last_step && pass_reg == count_reg - CW'(1))
                                  ? ST_DIV : ST_RD;
            ST_DIV:  if (bit_reg == '0) state_next = ST_OUT;
            ST_OUT:  state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && keep && !full)
            mem[count_reg[AW-1:0]] <= in_data.sample[14:0];
        else if (state_reg == ST_CMP && do_swap)
        begin
            mem[idx_reg]        <= rd_b_reg;
            mem[idx_reg + 1'b1] <= rd_a_reg;
        end
        if (state_reg == ST_RD)
        begin
            rd_a_reg <= mem[idx_reg];
            rd_b_reg <= mem[idx_reg + 1'b1];
        end
        if (state_reg == ST_DIV)
        begin
            med_lo_reg <= mem[AW'(half - CW'(1))];
            med_hi_reg <= mem[half[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            min_reg       <= PwrMax;
            max_reg       <= '0;
            sum_reg       <= '0;
            ok_reg        <= 1'b1;
            ovf_reg       <= 1'b0;
            pass_reg      <= '0;
            idx_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire && keep && full)
                        ovf_reg <= 1'b1;
                    else if (in_fire && keep)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (in_data.sample[14:0] < min_reg) min_reg <= in_data.sample[14:0];
                        if (in_data.sample[14:0] > max_reg) max_reg <= in_data.sample[14:0];
                        sum_reg <= sum_reg + SW'(in_data.sample[14:0]);
                        if (in_data.sample[14:0] < range_low_reg ||
                            in_data.sample[14:0] > range_high_reg)
                            ok_reg <= 1'b0;
                    end
                    pass_reg <= '0;
                    idx_reg  <= '0;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    bit_reg  <= ($clog2(SW+1))'(SW);
                end
                ST_CMP:
                begin
                    if (last_step)
                    begin
                        pass_reg <= pass_reg + 1'b1;
                        idx_reg  <= AW'(!pair_odd);
                    end
                    else
                        idx_reg <= idx_reg + AW'(2);
                end
                ST_DIV:
                begin
                    if (bit_reg != '0)
                    begin
                        bit_reg <= bit_reg - 1'b1;
                        if (!trial[SW])
                        begin
                            rem_reg <= trial[SW-1:0];
                            quo_reg <= {quo_reg[SW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[SW-2:0], 1'b0};
                        end
                    end
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (count_reg == '0)
                    begin
                        out_reg.min_power    <= '0;
                        out_reg.max_power    <= '0;
                        out_reg.mean_power   <= '0;
                        out_reg.median_power <= '0;
                        out_reg.all_in_range <= 1'b1;
                        out_reg.kept_count   <= '0;
                        out_reg.empty_res    <= 1'b1;
                    end
                    else
                    begin
                        out_reg.min_power    <= min_reg;
                        out_reg.max_power    <= max_reg;
                        out_reg.mean_power   <= quo_reg[14:0];
                        out_reg.median_power <= count_reg[0] ? med_hi_reg
                            : 15'(({1'b0, med_lo_reg} + {1'b0, med_hi_reg}) >> 1);
                        out_reg.all_in_range <= ok_reg;
                        out_reg.kept_count   <= 6'(count_reg);
                        out_reg.empty_res    <= 1'b0;
                    end
                    out_reg.overflow <= ovf_reg;
                    count_reg <= '0;
                    min_reg   <= PwrMax;
                    max_reg   <= '0;
                    sum_reg   <= '0;
                    ok_reg    <= 1'b1;
                    ovf_reg   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- tb/sample_set_statistics_checker.sv -----
// Checker for the sample set statistics unit: watches the sample, result and
// APB channels, predicts each result and compares it field by field.
// Depends on sss_pkg.
module sample_set_statistics_checker
    import sss_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MaxSamplesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [14:0] lo_bound;
    logic [14:0] hi_bound;
    logic [14:0] kept [MAX_SAMPLES];
    int unsigned n_kept;
    logic [14:0] cur_min;
    logic [14:0] cur_max;
    logic [19:0] cur_sum;
    logic        in_bounds;
    logic        dropped_full;
    out_item_t   stats_q[$];
    int          mismatches;

    assign fail_count = mismatches;
    assign pending    = stats_q.size();

    function automatic logic [14:0] median_kept();
        logic [14:0] srt [MAX_SAMPLES];
        logic [14:0] v;
        int j;
        for (int i = 0; i < n_kept; i++)
            srt[i] = kept[i];
        for (int i = 1; i < n_kept; i++)
        begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v)
            begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        if (n_kept % 2 == 0)
            return 15'((int'(srt[n_kept/2-1]) + int'(srt[n_kept/2])) / 2);
        return srt[n_kept/2];
    endfunction

    function automatic void field_check(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch %s: expected %0d, actual %0d",
                         $realtime, field, want, got);
        end
    endfunction

    task automatic clear_stats();
        n_kept       = 0;
        cur_min      = PwrMax;
        cur_max      = '0;
        cur_sum      = '0;
        in_bounds    = 1'b1;
        dropped_full = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        logic [14:0] v;
        if (!rst_n)
        begin
            lo_bound   = RangeLowReset;
            hi_bound   = RangeHighReset;
            mismatches = 0;
            stats_q.delete();
            clear_stats();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == RegRangeLow)
                    lo_bound = pwdata[14:0];
                else
                    hi_bound = pwdata[14:0];
            end
            if (out_valid && out_ready)
            begin
                if (stats_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected result transaction", $realtime);
                end
                else
                begin
                    exp_r = stats_q.pop_front();
                    field_check("min_power", exp_r.min_power, out_data.min_power);
                    field_check("max_power", exp_r.max_power, out_data.max_power);
                    field_check("mean_power", exp_r.mean_power, out_data.mean_power);
                    field_check("median_power", exp_r.median_power, out_data.median_power);
                    field_check("all_in_range", exp_r.all_in_range, out_data.all_in_range);
                    field_check("kept_count", exp_r.kept_count, out_data.kept_count);
                    field_check("empty_res", exp_r.empty_res, out_data.empty_res);
                    field_check("overflow", exp_r.overflow, out_data.overflow);
                end
            end
            if (in_valid && in_ready)
            begin
                if (!in_data.sample[15])
                begin
                    v = in_data.sample[14:0];
                    if (n_kept < MAX_SAMPLES)
                    begin
                        kept[n_kept] = v;
                        n_kept++;
                        if (v < cur_min) cur_min = v;
                        if (v > cur_max) cur_max = v;
                        cur_sum += 20'(v);
                        if (v < lo_bound || v > hi_bound)
                            in_bounds = 1'b0;
                    end
                    else
                        dropped_full = 1'b1;
                end
                if (in_data.last)
                begin
                    exp_r = '0;
                    exp_r.overflow = dropped_full;
                    if (n_kept == 0)
                    begin
                        exp_r.all_in_range = 1'b1;
                        exp_r.empty_res    = 1'b1;
                    end
                    else
                    begin
                        exp_r.min_power    = cur_min;
                        exp_r.max_power    = cur_max;
                        exp_r.mean_power   = 15'(cur_sum / n_kept);
                        exp_r.median_power = median_kept();
                        exp_r.all_in_range = in_bounds;
                        exp_r.kept_count   = 6'(n_kept);
                    end
                    stats_q.push_back(exp_r);
                    clear_stats();
                end
            end
        end
    end

endmodule

// ----- tb/sample_set_statistics_unit_tb.sv -----
// Testbench top for the sample set statistics unit: clock, reset, sample sets,
// APB range settings, result stalls and the verdict.
// Depends on sss_pkg, sample_set_statistics_unit and sample_set_statistics_checker.
module sample_set_statistics_unit_tb;
    import sss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 30000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    logic        steady_in = 1'b0;
    logic        stim_done = 1'b0;
    logic        rx_hold = 1'b0;
    logic [14:0] lo_now = RangeLowReset;
    logic [14:0] hi_now = RangeHighReset;
    int          items_sent = 0;
    int          sets_sent = 0;
    int          idle_cycles = 0;

    always #6 clk = ~clk;

    sample_set_statistics_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    sample_set_statistics_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    task automatic send_sample(input logic signed [15:0] s, input logic fin);
        @(negedge clk);
        while (!steady_in && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_data.sample <= s;
        in_data.last   <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic apb_write(input logic [0:0] reg_idx, input logic [14:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        psel     <= 1'b1;
        penable  <= 1'b0;
        pwrite   <= 1'b1;
        paddr    <= {reg_idx, 2'b00};
        pwdata   <= {17'b0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for the unit to drain, then set both bounds
    task automatic set_bounds(input logic [14:0] lo, input logic [14:0] hi);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        apb_write(RegRangeLow, lo);
        apb_write(RegRangeHigh, hi);
        lo_now = lo;
        hi_now = hi;
    endtask

    function automatic logic signed [15:0] pick_sample();
        int r;
        int a;
        int b;
        r = $urandom_range(99);
        if (r < 55)
        begin
            a = (lo_now < hi_now ? lo_now : hi_now) - 20;
            b = (lo_now < hi_now ? hi_now : lo_now) + 20;
            if (a < 0) a = 0;
            if (b > 32767) b = 32767;
            return 16'($urandom_range(b, a));
        end
        if (r < 70) return 16'($urandom);
        if (r < 80) return 16'($urandom_range(40, 0));
        if (r < 90) return 16'($urandom_range(32767, 32700));
        return 16'($urandom_range(32767, 0));
    endfunction

    task automatic send_set(input int len, input int neg_pct);
        logic signed [15:0] s;
        for (int i = 0; i < len; i++)
        begin
            s = pick_sample();
            if ($urandom_range(99) < neg_pct)
                s[15] = 1'b1;
            send_sample(s, i == len - 1);
        end
        sets_sent++;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(8, 1);
        if (r < 93) return $urandom_range(31, 9);
        return $urandom_range(38, 32);
    endfunction

    // result side: random stalls, one long hold, one stretch with no stalls
    initial
    begin
        int cyc;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (rx_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                rx_hold = 1'b0;
            end
            else if (cyc > 9000 && cyc < 13000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 38);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset bounds
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd160, 1'b0);
        send_sample(16'sd1440, 1'b1);
        send_sample(16'sd159, 1'b0);
        send_sample(16'sd1441, 1'b0);
        send_sample(16'sd500, 1'b0);
        send_sample(16'sd501, 1'b1);
        for (int i = 0; i < 34; i++)
            send_sample(16'(32767 - i * 700), i == 33);

        set_bounds(15'd32767, 15'd0);
        send_sample(16'sd100, 1'b0);
        send_sample(16'sd7, 1'b1);
        set_bounds(15'd0, 15'd32767);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd5, 1'b1);

        while (items_sent < 1950)
        begin
            case ($urandom_range(4))
                0: set_bounds(RangeLowReset, RangeHighReset);
                1: set_bounds(15'd0, 15'd32767);
                2: set_bounds(15'd32767, 15'd0);
                default: set_bounds(15'($urandom), 15'($urandom));
            endcase
            for (int k = 0; k < 40 && items_sent < 1950; k++)
            begin
                steady_in = (items_sent > 700 && items_sent < 1000);
                if (sets_sent == 30)
                    rx_hold = 1'b1;
                if ($urandom_range(99) < 4)
                    send_set($urandom_range(5, 1), 100);
                else
                    send_set(pick_len(), $urandom_range(99) < 70 ? 0 : 25);
            end
        end
        steady_in = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/sss_pkg.sv
design/sample_set_statistics_unit.sv
tb/sample_set_statistics_checker.sv
tb/sample_set_statistics_unit_tb.sv
